@@ rtl/i2cmts_pkg.sv @@
// Types and constants for the I2C master transfer sequencer.
// Holds bus status codes, action and error encodings, and the state/result structs.
// No dependencies.
`default_nettype none

package i2cmts_pkg;

  localparam int POS_W  = 9;
  localparam int BYTE_W = 8;

  // byte-level bus status codes (master only)
  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_TX_ADDR_ACK = 8'h18;
  localparam logic [7:0] ST_TX_ADDR_NAK = 8'h20;
  localparam logic [7:0] ST_TX_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_TX_DATA_NAK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_RX_ADDR_ACK = 8'h40;
  localparam logic [7:0] ST_RX_ADDR_NAK = 8'h48;
  localparam logic [7:0] ST_RX_DATA_ACK = 8'h50;
  localparam logic [7:0] ST_RX_DATA_NAK = 8'h58;
  localparam logic [7:0] ST_NO_INFO     = 8'hF8;

  // configuration register indexes
  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_XFER_LEN   = 2'd1;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_CLR_FLAG  = 3'd1,
    ACT_START_ACK = 3'd2,
    ACT_ACK       = 3'd3,
    ACT_NACK      = 3'd4,
    ACT_STOP      = 3'd5,
    ACT_RESTART   = 3'd6
  } action_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_DEVICE = 3'd1,
    ERR_ARB_LOST  = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_BUS       = 3'd4
  } error_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             ready;
    error_t           error;
  } seq_state_t;

  typedef struct packed {
    action_t           action;
    logic              send_valid;
    logic [BYTE_W-1:0] send_byte;
    logic              store_valid;
    logic [BYTE_W-1:0] store_index;
    logic [BYTE_W-1:0] store_byte;
    error_t            error;
    logic              ready;
  } seq_result_t;

endpackage

`default_nettype wire

@@ rtl/i2cmts_step.sv @@
// Per-item decode of one bus status event: next sequencer state and the result item.
// Pure combinational; depends on i2cmts_pkg.
`default_nettype none

module i2cmts_step import i2cmts_pkg::*; (
  input  wire seq_state_t        state_i,
  input  wire logic [POS_W-1:0]  len_i,
  input  wire logic [BYTE_W-1:0] addr_i,
  input  wire logic [7:0]        status_i,
  input  wire logic [BYTE_W-1:0] rx_i,
  input  wire logic [BYTE_W-1:0] tx_i,
  output seq_state_t             state_o,
  output seq_result_t            result_o
);

  logic            has_room;
  logic            check_more;
  logic [POS_W:0]  pos_plus1;

  assign has_room = state_i.position < len_i;

  always_comb begin
    state_o    = state_i;
    result_o   = '0;
    check_more = 1'b0;
    case (status_i)
      ST_START, ST_RESTART: begin
        state_o.ready       = 1'b0;
        result_o.send_valid = 1'b1;
        result_o.send_byte  = addr_i;
        result_o.action     = ACT_START_ACK;
      end
      ST_TX_ADDR_ACK, ST_TX_DATA_ACK: begin
        if (has_room) begin
          result_o.send_valid  = 1'b1;
          result_o.send_byte   = tx_i;
          result_o.store_index = state_i.position[BYTE_W-1:0];
          state_o.position     = state_i.position + 1'b1;
          result_o.action      = ACT_ACK;
        end else begin
          result_o.action = ACT_STOP;
          state_o.ready   = 1'b1;
        end
      end
      ST_RX_DATA_NAK, ST_RX_DATA_ACK: begin
        if (has_room) begin
          result_o.store_valid = 1'b1;
          result_o.store_index = state_i.position[BYTE_W-1:0];
          result_o.store_byte  = rx_i;
          state_o.position     = state_i.position + 1'b1;
        end else begin
          state_o.error = ERR_OVERFLOW;
        end
        if (status_i == ST_RX_DATA_NAK) begin
          result_o.action = ACT_STOP;
          state_o.ready   = 1'b1;
        end else begin
          check_more = 1'b1;
        end
      end
      ST_TX_ADDR_NAK, ST_RX_ADDR_NAK: begin
        state_o.error   = ERR_NO_DEVICE;
        result_o.action = ACT_STOP;
        state_o.ready   = 1'b1;
      end
      ST_TX_DATA_NAK: begin
        result_o.action = ACT_STOP;
        state_o.ready   = 1'b1;
      end
      ST_ARB_LOST: begin
        state_o.error   = ERR_ARB_LOST;
        result_o.action = ACT_RESTART;
      end
      ST_RX_ADDR_ACK: check_more = 1'b1;
      ST_NO_INFO:     result_o.action = ACT_CLR_FLAG;
      ST_BUS_ERROR: begin
        state_o.error   = ERR_BUS;
        result_o.action = ACT_STOP;
        state_o.ready   = 1'b1;
      end
      default: ;
    endcase

    // ack only if another byte will follow the one now arriving
    pos_plus1 = {1'b0, state_o.position} + 1'b1;
    if (check_more) begin
      result_o.action = (pos_plus1 < {1'b0, len_i}) ? ACT_ACK : ACT_NACK;
    end
    result_o.error = state_o.error;
    result_o.ready = state_o.ready;
  end

endmodule

`default_nettype wire

@@ rtl/i2c_master_transfer_sequencer_unit.sv @@
// I2C master transfer sequencer: one result item per bus status item.
// The result is registered into the result register, or into the skid register if that one is held.
// Throughput: one item per cycle while the skid register is empty; a two-entry output stage (result register
// plus skid register) keeps input ready while one result waits.
// Reset (rst_n, synchronous): position 0, ready 1, no error, address, length and valid flags 0.
// Depends on i2cmts_pkg and i2cmts_step.
`default_nettype none

module i2c_master_transfer_sequencer_unit import i2cmts_pkg::*; #(
  parameter int MAX_LENGTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_status_code,
  input  wire logic [7:0]  in_rx_byte,
  input  wire logic [7:0]  in_tx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_bus_action,
  output logic             out_send_valid,
  output logic [7:0]       out_send_byte,
  output logic             out_store_valid,
  output logic [7:0]       out_store_index,
  output logic [7:0]       out_store_byte,
  output logic [2:0]       out_error_out,
  output logic             out_ready_out
);

  localparam int LEN_MAX_FIELD = (1 << POS_W) - 1;
  localparam int LEN_CAP_INT   = (MAX_LENGTH > LEN_MAX_FIELD) ? LEN_MAX_FIELD : MAX_LENGTH;
  localparam logic [POS_W-1:0] LEN_CAP = LEN_CAP_INT[POS_W-1:0];

  logic [BYTE_W-1:0] addr_r;
  logic [POS_W-1:0]  len_r;     // already clamped to the cap
  seq_state_t        state_r, state_nxt;
  seq_result_t       res_new;
  seq_result_t       out_r, skid_r;
  logic              out_vld_r, skid_vld_r;
  logic              in_acc, out_acc;

  assign in_ready = ~skid_vld_r;
  assign in_acc   = in_valid & in_ready;
  assign out_acc  = out_vld_r & out_ready;

  i2cmts_step u_step (
    .state_i  (state_r),
    .len_i    (len_r),
    .addr_i   (addr_r),
    .status_i (in_status_code),
    .rx_i     (in_rx_byte),
    .tx_i     (in_tx_byte),
    .state_o  (state_nxt),
    .result_o (res_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      len_r   <= '0;
      state_r <= '{position: '0, ready: 1'b1, error: ERR_NONE};
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLAVE_ADDR: begin
          addr_r           <= cfg_wdata[BYTE_W-1:0];
          state_r.position <= '0;
        end
        REG_XFER_LEN: begin
          len_r            <= (cfg_wdata > LEN_CAP) ? LEN_CAP : cfg_wdata;
          state_r.position <= '0;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // output stage: result register in front, skid register behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_acc) begin
          out_r      <= skid_r;
          skid_vld_r <= 1'b0;
        end
      end else if (in_acc) begin
        if (out_vld_r && !out_ready) begin
          skid_r     <= res_new;
          skid_vld_r <= 1'b1;
        end else begin
          out_r     <= res_new;
          out_vld_r <= 1'b1;
        end
      end else if (out_acc) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_vld_r;
  assign out_bus_action  = out_r.action;
  assign out_send_valid  = out_r.send_valid;
  assign out_send_byte   = out_r.send_byte;
  assign out_store_valid = out_r.store_valid;
  assign out_store_index = out_r.store_index;
  assign out_store_byte  = out_r.store_byte;
  assign out_error_out   = out_r.error;
  assign out_ready_out   = out_r.ready;

endmodule

`default_nettype wire
